@@ hw/rtl/twq_pkg.sv @@
// shared types, constants and control structs for the tile work queue
package twq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int COORD_BITS  = 16;
   localparam int FIELD_BITS  = 16;
   localparam int DRAW_BITS   = 16;
   localparam int POP_BITS    = 6;
   localparam int OP_BITS     = 2;
   localparam int STAT_BITS   = 3;
   localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int HELD_BITS   = 7;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH    = 2'd0,
      OP_POP_AT  = 2'd1,
      OP_POP_RND = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [STAT_BITS-1:0] {
      ST_PUSHED    = 3'd0,
      ST_POPPED    = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_CLEARED   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CNT_HOLD  = 2'd0,
      CNT_INC   = 2'd1,
      CNT_DEC   = 2'd2,
      CNT_CLEAR = 2'd3
   } count_op_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] xs;
      logic [COORD_BITS-1:0] xe;
      logic [COORD_BITS-1:0] ys;
      logic [COORD_BITS-1:0] ye;
   } rect_type;

   // controller to datapath
   typedef struct packed {
      logic         capture;
      logic         push_write;
      logic         read_pos;
      logic         grab;
      logic         read_next;
      logic         shift;
      logic         post;
      status_type   post_status;
      count_op_type count_op;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type operation;
      logic   full;
      logic   pos_ok;
      logic   next_ok;
      logic   after_ok;
   } stat_type;

endpackage

@@ hw/rtl/twq_req_if.sv @@
// request channel interface: operation and its operands
interface twq_req_if
   import twq_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [OP_BITS-1:0]    operation;
   logic [FIELD_BITS-1:0] x_start;
   logic [FIELD_BITS-1:0] x_end;
   logic [FIELD_BITS-1:0] y_start;
   logic [FIELD_BITS-1:0] y_end;
   logic [POP_BITS-1:0]   pop_index;
   logic [DRAW_BITS-1:0]  random_draw;

   modport source (
      output valid, operation, x_start, x_end, y_start, y_end, pop_index, random_draw,
      input  ready
   );
   modport sink (
      input  valid, operation, x_start, x_end, y_start, y_end, pop_index, random_draw,
      output ready
   );
endinterface

@@ hw/rtl/twq_rsp_if.sv @@
// response channel interface: status, popped rectangle and queue fill
interface twq_rsp_if
   import twq_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [STAT_BITS-1:0]  status;
   logic [FIELD_BITS-1:0] out_x_start;
   logic [FIELD_BITS-1:0] out_x_end;
   logic [FIELD_BITS-1:0] out_y_start;
   logic [FIELD_BITS-1:0] out_y_end;
   logic [HELD_BITS-1:0]  entries_held;

   modport source (
      output valid, status, out_x_start, out_x_end, out_y_start, out_y_end, entries_held,
      input  ready
   );
   modport sink (
      input  valid, status, out_x_start, out_x_end, out_y_start, out_y_end, entries_held,
      output ready
   );
endinterface

@@ hw/rtl/twq_ctrl.sv @@
// controller state machine: sequences push, pop, clear, shift and response
module twq_ctrl
   import twq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_GRAB,
      S_SHIFT,
      S_RESPOND
   } state_type;

   state_type    state_ff, state_in;
   status_type   result_ff, result_in;
   count_op_type cntop_ff, cntop_in;
   logic         rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      result_in = result_ff;
      cntop_in  = cntop_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.post_status = result_ff;
      cmd.count_op    = cntop_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            case (stat.operation)
               OP_PUSH: begin
                  state_in = S_RESPOND;
                  if (stat.full) begin
                     result_in = ST_FULL;
                     cntop_in  = CNT_HOLD;
                  end else begin
                     cmd.push_write = 1'b1;
                     result_in      = ST_PUSHED;
                     cntop_in       = CNT_INC;
                  end
               end
               OP_POP_AT, OP_POP_RND: begin
                  if (stat.pos_ok) begin
                     cmd.read_pos = 1'b1;
                     state_in     = S_GRAB;
                  end else begin
                     result_in = ST_NOT_FOUND;
                     cntop_in  = CNT_HOLD;
                     state_in  = S_RESPOND;
                  end
               end
               default: begin
                  result_in = ST_CLEARED;
                  cntop_in  = CNT_CLEAR;
                  state_in  = S_RESPOND;
               end
            endcase
         end
         S_GRAB: begin
            cmd.grab      = 1'b1;
            cmd.read_next = 1'b1;
            result_in     = ST_POPPED;
            cntop_in      = CNT_DEC;
            state_in      = stat.next_ok ? S_SHIFT : S_RESPOND;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (!stat.after_ok) begin
               state_in = S_RESPOND;
            end
         end
         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.post = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid: set on post, cleared once taken
   always_comb begin
      if (cmd.post) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         result_ff    <= ST_PUSHED;
         cntop_ff     <= CNT_HOLD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         result_ff    <= result_in;
         cntop_ff     <= cntop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/twq_dp.sv @@
// datapath: entry memory, count, position math and result registers
module twq_dp
   import twq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [OP_BITS-1:0]    req_operation,
   input  logic [FIELD_BITS-1:0] req_x_start,
   input  logic [FIELD_BITS-1:0] req_x_end,
   input  logic [FIELD_BITS-1:0] req_y_start,
   input  logic [FIELD_BITS-1:0] req_y_end,
   input  logic [POP_BITS-1:0]   req_pop_index,
   input  logic [DRAW_BITS-1:0]  req_random_draw,
   output logic [STAT_BITS-1:0]  rsp_status,
   output logic [FIELD_BITS-1:0] rsp_out_x_start,
   output logic [FIELD_BITS-1:0] rsp_out_x_end,
   output logic [FIELD_BITS-1:0] rsp_out_y_start,
   output logic [FIELD_BITS-1:0] rsp_out_y_end,
   output logic [HELD_BITS-1:0]  rsp_entries_held
);

   localparam int PROD_BITS = DRAW_BITS + CNT_BITS;

   rect_type mem [QUEUE_DEPTH];

   logic [CNT_BITS-1:0]  count_ff, count_in;
   op_type               op_ff;
   rect_type             rect_ff;
   logic [CNT_BITS-1:0]  pos_ff, pos_in;
   logic [IDX_BITS-1:0]  cursor_ff;
   rect_type             rd_data_ff;
   rect_type             grab_ff;
   logic [IDX_BITS-1:0]  rd_addr;
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr;
   rect_type             wr_data;
   logic [PROD_BITS-1:0] product;
   logic [CNT_BITS:0]    next_pos;
   logic [CNT_BITS:0]    after_pos;
   status_type           res_status_ff;
   rect_type             res_rect_ff;
   logic [CNT_BITS-1:0]  res_held_ff;

   // position of the pop: given index or scaled random draw
   assign product = PROD_BITS'(req_random_draw) * PROD_BITS'(count_ff);
   always_comb begin
      if (op_type'(req_operation) == OP_POP_RND) begin
         pos_in = product[PROD_BITS-1:DRAW_BITS];
      end else begin
         pos_in = CNT_BITS'(req_pop_index);
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= op_type'(req_operation);
         rect_ff.xs <= COORD_BITS'(req_x_start);
         rect_ff.xe <= COORD_BITS'(req_x_end);
         rect_ff.ys <= COORD_BITS'(req_y_start);
         rect_ff.ye <= COORD_BITS'(req_y_end);
         pos_ff     <= pos_in;
      end
   end

   // shift cursor: loaded with the pop position, steps once per moved entry
   always_ff @(posedge clock) begin
      if (cmd.read_pos) begin
         cursor_ff <= pos_ff[IDX_BITS-1:0];
      end else if (cmd.shift) begin
         cursor_ff <= cursor_ff + IDX_BITS'(1);
      end
   end

   // status toward the controller
   assign next_pos  = (CNT_BITS + 1)'(cursor_ff) + (CNT_BITS + 1)'(1);
   assign after_pos = (CNT_BITS + 1)'(cursor_ff) + (CNT_BITS + 1)'(2);
   always_comb begin
      stat.operation = op_ff;
      stat.full      = (count_ff >= CNT_BITS'(QUEUE_DEPTH));
      stat.pos_ok    = (pos_ff < count_ff);
      stat.next_ok   = (next_pos < (CNT_BITS + 1)'(count_ff));
      stat.after_ok  = (after_pos < (CNT_BITS + 1)'(count_ff));
   end

   // memory port selection
   always_comb begin
      if (cmd.read_pos) begin
         rd_addr = pos_ff[IDX_BITS-1:0];
      end else if (cmd.shift) begin
         rd_addr = after_pos[IDX_BITS-1:0];
      end else begin
         rd_addr = next_pos[IDX_BITS-1:0];
      end
      wr_en   = cmd.push_write || cmd.shift;
      wr_addr = cmd.shift ? cursor_ff : count_ff[IDX_BITS-1:0];
      wr_data = cmd.shift ? rd_data_ff : rect_ff;
   end

   // entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // popped entry
   always_ff @(posedge clock) begin
      if (cmd.grab) begin
         grab_ff <= rd_data_ff;
      end
   end

   // entry count update, applied when the result is posted
   always_comb begin
      count_in = count_ff;
      case (cmd.count_op)
         CNT_INC:   count_in = count_ff + CNT_BITS'(1);
         CNT_DEC:   count_in = count_ff - CNT_BITS'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.post) begin
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.post) begin
         res_status_ff <= cmd.post_status;
         res_rect_ff   <= (cmd.post_status == ST_POPPED) ? grab_ff : '0;
         res_held_ff   <= count_in;
      end
   end

   assign rsp_status       = res_status_ff;
   assign rsp_out_x_start  = FIELD_BITS'(res_rect_ff.xs);
   assign rsp_out_x_end    = FIELD_BITS'(res_rect_ff.xe);
   assign rsp_out_y_start  = FIELD_BITS'(res_rect_ff.ys);
   assign rsp_out_y_end    = FIELD_BITS'(res_rect_ff.ye);
   assign rsp_entries_held = HELD_BITS'(res_held_ff);

endmodule

@@ hw/rtl/tile_work_queue_indexed_pop.sv @@
// top level: ordered tile work queue with push, pop at index, pop random, clear
// each request is captured on accept, executed, and its result posted from the
//   respond state; a pop at position p with n entries grabs that entry, then moves the
//   n - p - 1 entries behind it up by one, closing up one entry per cycle
// a new request is accepted only after the previous result has been posted
// reset: queue empty at once, no clearing pass; store contents undefined until pushed
module tile_work_queue_indexed_pop
   import twq_pkg::*;
(
   input logic   clock,
   input logic   reset,
   twq_req_if.sink   req_ch,
   twq_rsp_if.source rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   twq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and result
   twq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_ch.operation),
      .req_x_start      (req_ch.x_start),
      .req_x_end        (req_ch.x_end),
      .req_y_start      (req_ch.y_start),
      .req_y_end        (req_ch.y_end),
      .req_pop_index    (req_ch.pop_index),
      .req_random_draw  (req_ch.random_draw),
      .rsp_status       (rsp_ch.status),
      .rsp_out_x_start  (rsp_ch.out_x_start),
      .rsp_out_x_end    (rsp_ch.out_x_end),
      .rsp_out_y_start  (rsp_ch.out_y_start),
      .rsp_out_y_end    (rsp_ch.out_y_end),
      .rsp_entries_held (rsp_ch.entries_held)
   );

endmodule
